[rtl/lxr_pkg.sv]
// Shared types and constants for the LFSR/xorshift random generator.
package lxr_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned NUM_WORDS = 4;
   localparam int unsigned RAND_W   = 15;
   localparam int unsigned STEP_W   = 3;
   localparam int unsigned NUM_TEMPER_STEPS = 5;

   localparam logic [WORD_W-1:0] SEED_MASK = 32'hcafe_babe;
   localparam logic [WORD_W-1:0] SEED_MULT = 32'h0000_0875;
   localparam logic [WORD_W-1:0] FEEDBACK  = 32'h8000_000b;
   localparam int unsigned       TAP_BIT   = 30;

   localparam logic MODE_SEED = 1'b0;
   localparam logic MODE_DRAW = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_SHIFT,
      ST_TEMPER,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       left;
      logic [4:0] amount;
   } shift_op_type;

   function automatic shift_op_type temper_op(input logic [STEP_W-1:0] step);
      shift_op_type op;
      unique case (step)
         3'd0:    op = '{left: 1'b0, amount: 5'd3};
         3'd1:    op = '{left: 1'b1, amount: 5'd5};
         3'd2:    op = '{left: 1'b0, amount: 5'd11};
         3'd3:    op = '{left: 1'b1, amount: 5'd17};
         default: op = '{left: 1'b0, amount: 5'd16};
      endcase
      return op;
   endfunction

endpackage

[rtl/lxr_if.sv]
// Valid/ready channel interfaces for request and response transactions.
interface lxr_req_if;
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic [lxr_pkg::WORD_W-1:0]   seed_value;

   modport source (output valid, output mode, output seed_value, input ready);
   modport sink   (input valid, input mode, input seed_value, output ready);
endinterface

interface lxr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lxr_pkg::RAND_W-1:0]   random_value;

   modport source (output valid, output random_value, input ready);
   modport sink   (input valid, input random_value, output ready);
endinterface

[rtl/lfsr_xorshift_random_core.sv]
// Top level of the LFSR/xorshift random generator.
// A seed transaction (mode 0) loads the four 32-bit state words one per cycle through a
// single constant multiplier; it returns nothing.
// A draw transaction (mode 1) does the 128-bit shift and feedback in the shift state, then
// runs five tempering steps through one shared shift/XOR unit, then lands in the response
// register once the response side is free to take it.
// Requests are taken only while the sequencer is idle; a finished response may still be
// waiting downstream while the next request is accepted. After reset the state is zero and
// draws return 0 until a seed transaction arrives.
module lfsr_xorshift_random_core (
   input  logic         clock,
   input  logic         reset,
   lxr_req_if.sink      req_chan,
   lxr_rsp_if.source    rsp_chan
);

   lxr_pkg::state_type state_ff, state_in;

   logic [lxr_pkg::WORD_W-1:0] words_ff [lxr_pkg::NUM_WORDS];
   logic [lxr_pkg::WORD_W-1:0] words_in [lxr_pkg::NUM_WORDS];
   logic [lxr_pkg::WORD_W-1:0] seed_ff, seed_in;
   logic [lxr_pkg::WORD_W-1:0] temper_ff, temper_in;
   logic [lxr_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [lxr_pkg::RAND_W-1:0] rsp_data_ff, rsp_data_in;

   logic                       req_fire;
   logic                       out_free;
   logic [lxr_pkg::WORD_W-1:0] seed_word;
   logic [lxr_pkg::WORD_W-1:0] seed_next;
   logic [lxr_pkg::WORD_W-1:0] shifted;
   lxr_pkg::shift_op_type      op;
   logic                       tap;

   assign req_chan.ready        = (state_ff == lxr_pkg::ST_IDLE);
   assign req_fire              = req_chan.valid && req_chan.ready;
   assign out_free              = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.random_value = rsp_data_ff;

   // seed sequencing unit
   assign seed_word = seed_ff & lxr_pkg::SEED_MASK;
   assign seed_next = 32'(seed_ff * lxr_pkg::SEED_MULT) + 32'd1;

   // shared tempering shift/XOR unit
   assign op      = lxr_pkg::temper_op(cnt_ff);
   assign shifted = op.left ? (temper_ff << op.amount) : (temper_ff >> op.amount);
   assign tap     = words_ff[lxr_pkg::NUM_WORDS-1][lxr_pkg::TAP_BIT];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lxr_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_chan.mode == lxr_pkg::MODE_SEED) ? lxr_pkg::ST_SEED
                                                                 : lxr_pkg::ST_SHIFT;
            end
         end
         lxr_pkg::ST_SEED: begin
            if (cnt_ff == 3'(lxr_pkg::NUM_WORDS - 1)) state_in = lxr_pkg::ST_IDLE;
         end
         lxr_pkg::ST_SHIFT: state_in = lxr_pkg::ST_TEMPER;
         lxr_pkg::ST_TEMPER: begin
            if (cnt_ff == 3'(lxr_pkg::NUM_TEMPER_STEPS - 1)) state_in = lxr_pkg::ST_OUT;
         end
         lxr_pkg::ST_OUT: begin
            if (out_free) state_in = lxr_pkg::ST_IDLE;
         end
         default: state_in = lxr_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      for (int i = 0; i < lxr_pkg::NUM_WORDS; i++) words_in[i] = words_ff[i];
      seed_in      = seed_ff;
      temper_in    = temper_ff;
      cnt_in       = cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         lxr_pkg::ST_IDLE: begin
            seed_in = req_chan.seed_value;
            cnt_in  = '0;
         end
         lxr_pkg::ST_SEED: begin
            words_in[cnt_ff[1:0]] = seed_word;
            if (cnt_ff == 3'(lxr_pkg::NUM_WORDS - 1) && seed_word == '0) begin
               words_in[cnt_ff[1:0]] = lxr_pkg::SEED_MASK;
            end
            seed_in = seed_next;
            cnt_in  = cnt_ff + 3'd1;
         end
         lxr_pkg::ST_SHIFT: begin
            words_in[0] = {words_ff[0][lxr_pkg::WORD_W-2:0], 1'b0};
            for (int i = 1; i < lxr_pkg::NUM_WORDS; i++) begin
               words_in[i] = {words_ff[i][lxr_pkg::WORD_W-2:0],
                              words_ff[i-1][lxr_pkg::WORD_W-1]};
            end
            if (tap) words_in[0] = words_in[0] ^ lxr_pkg::FEEDBACK;
            temper_in = words_in[0];
            cnt_in    = '0;
         end
         lxr_pkg::ST_TEMPER: begin
            temper_in = temper_ff ^ shifted;
            cnt_in    = cnt_ff + 3'd1;
         end
         lxr_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_data_in  = temper_ff[lxr_pkg::RAND_W-1:0];
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lxr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         for (int i = 0; i < lxr_pkg::NUM_WORDS; i++) words_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         for (int i = 0; i < lxr_pkg::NUM_WORDS; i++) words_ff[i] <= words_in[i];
      end
   end

   always_ff @(posedge clock) begin
      seed_ff     <= seed_in;
      temper_ff   <= temper_in;
      rsp_data_ff <= rsp_data_in;
   end

   // top word is never left zero by a seed transaction
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == lxr_pkg::ST_SEED && cnt_ff == 3'(lxr_pkg::NUM_WORDS - 1))
      |=> (words_ff[lxr_pkg::NUM_WORDS-1] != '0))
      else $error("top state word zero after seed");

   // a new response is only raised from the output state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == lxr_pkg::ST_OUT))
      else $error("response raised outside output state");

   // seed sequence returns to idle after all words are loaded
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.mode == lxr_pkg::MODE_SEED) |-> ##5 (state_ff == lxr_pkg::ST_IDLE))
      else $error("seed sequence length wrong");

   // draw reaches the output state after shift and all tempering steps
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.mode == lxr_pkg::MODE_DRAW) |-> ##7 (state_ff == lxr_pkg::ST_OUT))
      else $error("draw sequence length wrong");

endmodule

[test/lxr_tb_pkg.sv]
// Scoreboard class for the LFSR/xorshift random generator testbench.
package lxr_tb_pkg;

   class draw_scoreboard;
      logic [lxr_pkg::NUM_WORDS*lxr_pkg::WORD_W-1:0] lfsr_state = '0;
      logic [lxr_pkg::RAND_W-1:0]                    expected_draws[$];
      int unsigned                                   errors = 0;

      // Accepted request transaction: reseed or advance the generator.
      function void note_request(input logic mode, input logic [lxr_pkg::WORD_W-1:0] seed);
         logic [lxr_pkg::WORD_W-1:0] s;
         logic [lxr_pkg::WORD_W-1:0] h;
         logic                       tap;
         if (mode == lxr_pkg::MODE_SEED) begin
            s = seed;
            for (int i = 0; i < lxr_pkg::NUM_WORDS; i++) begin
               lfsr_state[i*lxr_pkg::WORD_W +: lxr_pkg::WORD_W] = s & lxr_pkg::SEED_MASK;
               s = s * lxr_pkg::SEED_MULT + 1;
            end
            if (lfsr_state[3*lxr_pkg::WORD_W +: lxr_pkg::WORD_W] == '0)
               lfsr_state[3*lxr_pkg::WORD_W +: lxr_pkg::WORD_W] = lxr_pkg::SEED_MASK;
         end else begin
            tap = lfsr_state[3*lxr_pkg::WORD_W + lxr_pkg::TAP_BIT];
            lfsr_state = lfsr_state << 1;
            if (tap)
               lfsr_state[lxr_pkg::WORD_W-1:0] = lfsr_state[lxr_pkg::WORD_W-1:0]
                                                 ^ lxr_pkg::FEEDBACK;
            h = lfsr_state[lxr_pkg::WORD_W-1:0];
            h = h ^ (h >> 3);
            h = h ^ (h << 5);
            h = h ^ (h >> 11);
            h = h ^ (h << 17);
            h = h ^ (h >> 16);
            expected_draws.push_back(h[lxr_pkg::RAND_W-1:0]);
         end
      endfunction

      function void check_draw(input logic [lxr_pkg::RAND_W-1:0] got);
         logic [lxr_pkg::RAND_W-1:0] want;
         if (expected_draws.size() == 0) begin
            $error("random_value: no draw pending, got %0d", got);
            errors++;
         end else begin
            want = expected_draws.pop_front();
            if (got !== want) begin
               $error("random_value: expected %0d, got %0d", want, got);
               errors++;
            end
         end
      endfunction

      function int unsigned pending();
         return expected_draws.size();
      endfunction
   endclass

endpackage

[test/tb_top.sv]
// Top-level testbench for lfsr_xorshift_random_core.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned IDLE_PCT     = 37;
   localparam int unsigned RANDOM_ITEMS = 1680;
   localparam int unsigned QUIET_LIMIT  = 4000;
   localparam int unsigned DRAIN_CYCLES = 24;

   logic                       clock;
   logic                       reset;
   bit                         sender_idles;
   bit                         receiver_stalls;
   int unsigned                quiet_cycles;
   lxr_tb_pkg::draw_scoreboard sb;

   lxr_req_if req_if();
   lxr_rsp_if rsp_if();

   lfsr_xorshift_random_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic send_request(input logic mode, input logic [lxr_pkg::WORD_W-1:0] seed);
      while (sender_idles && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.mode       <= mode;
      req_if.seed_value <= seed;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      while (sb.pending() != 0)
         @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_if.ready <= !receiver_stalls || ($urandom_range(99) >= IDLE_PCT);
   end

   // transaction monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_if.valid && req_if.ready)
            sb.note_request(req_if.mode, req_if.seed_value);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_draw(rsp_if.random_value);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      logic [lxr_pkg::WORD_W-1:0] mult_inv;
      logic [lxr_pkg::WORD_W-1:0] zero_top_seed;
      int unsigned                roll;
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.mode       = lxr_pkg::MODE_DRAW;
      req_if.seed_value = '0;
      rsp_if.ready      = 1'b0;
      sender_idles      = 1'b1;
      receiver_stalls   = 1'b1;
      sb = new;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // seed whose fourth word comes out zero and must be forced to the mask
      mult_inv = lxr_pkg::SEED_MULT;
      repeat (5) mult_inv = mult_inv * (2 - lxr_pkg::SEED_MULT * mult_inv);
      zero_top_seed = '0;
      repeat (3) zero_top_seed = (zero_top_seed - 1) * mult_inv;

      // unseeded draws stay zero
      send_request(lxr_pkg::MODE_DRAW, '0);
      send_request(lxr_pkg::MODE_DRAW, '1);
      send_request(lxr_pkg::MODE_SEED, '0);
      repeat (3) send_request(lxr_pkg::MODE_DRAW, $urandom());
      send_request(lxr_pkg::MODE_SEED, '1);
      repeat (3) send_request(lxr_pkg::MODE_DRAW, '1);
      send_request(lxr_pkg::MODE_SEED, zero_top_seed);
      repeat (3) send_request(lxr_pkg::MODE_DRAW, '0);
      send_request(lxr_pkg::MODE_SEED, lxr_pkg::SEED_MASK);
      repeat (2) send_request(lxr_pkg::MODE_DRAW, $urandom());
      send_request(lxr_pkg::MODE_SEED, ~lxr_pkg::SEED_MASK);
      repeat (2) send_request(lxr_pkg::MODE_DRAW, $urandom());
      send_request(lxr_pkg::MODE_SEED, 32'h8000_0000);
      send_request(lxr_pkg::MODE_DRAW, '0);

      req_if.valid <= 1'b0;
      wait_for_drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         sender_idles    = !(n >= 600 && n < 900);
         receiver_stalls = !(n >= 600 && n < 900);
         if (n == 1200) begin
            req_if.valid <= 1'b0;
            wait_for_drain();
         end
         roll = $urandom_range(99);
         if (roll < 12)
            send_request(lxr_pkg::MODE_SEED, $urandom());
         else if (roll < 14)
            send_request(lxr_pkg::MODE_SEED, roll[0] ? '1 : '0);
         else
            send_request(lxr_pkg::MODE_DRAW, $urandom());
      end
      req_if.valid <= 1'b0;

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
